// ----- rtl/geq_pkg.sv -----
package geq_pkg;

  // delay and running-value format: Q9.23 in 32 bits
  localparam int DELAY_W   = 32;
  localparam int ACC_W     = 64;
  localparam int COEF_FRAC = 22;
  localparam int GAIN_FRAC = 19;

  // -1.005 in Q2.22
  localparam int K_W = 24;
  localparam logic signed [K_W-1:0] NEG_ONE_P005 = -24'sd4215276;

  localparam int BAND_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BANDS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RESET_NUM_CHANNELS = 4'd2;
  localparam logic [CFG_DATA_W-1:0] RESET_ACTIVE_BANDS = 4'd10;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    MS_Y_B0,
    MS_D1_A0,
    MS_D2_A1,
    MS_D2_K,
    MS_M_G
  } mul_sel_t;

  typedef struct packed {
    logic     y_load;
    mul_sel_t mul_sel;
    logic     acc_ld;
    logic     acc_add;
    logic     w_cap;
    logic     m_cap;
    logic     y_upd;
  } mac_ctl_t;

endpackage

// ----- rtl/geq_if.sv -----
interface geq_in_if #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
);
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           last_in;
  logic [geq_pkg::BAND_W-1:0]     band;
  logic signed [COEF_WIDTH-1:0]   coef_a0;
  logic signed [COEF_WIDTH-1:0]   coef_a1;
  logic signed [COEF_WIDTH-1:0]   coef_b0;
  logic signed [COEF_WIDTH-1:0]   band_gain;

  modport source (
    output valid, action, sample_in, last_in, band, coef_a0, coef_a1, coef_b0, band_gain,
    input  ready
  );
  modport sink (
    input  valid, action, sample_in, last_in, band, coef_a0, coef_a1, coef_b0, band_gain,
    output ready
  );
endinterface

interface geq_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink (input valid, sample_out, last_out, output ready);
endinterface

interface geq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [geq_pkg::CFG_IDX_W-1:0]    index;
  logic [geq_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/geq_ram.sv -----
module geq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/geq_mac.sv -----
module geq_mac #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                                   clk,
  input  geq_pkg::mac_ctl_t                      ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample,
  input  logic signed [geq_pkg::DELAY_W-1:0]     d1,
  input  logic signed [geq_pkg::DELAY_W-1:0]     d2,
  input  logic signed [COEF_WIDTH-1:0]           a0,
  input  logic signed [COEF_WIDTH-1:0]           a1,
  input  logic signed [COEF_WIDTH-1:0]           b0,
  input  logic signed [COEF_WIDTH-1:0]           g,
  output logic signed [SAMPLE_WIDTH-1:0]         y_sat,
  output logic signed [geq_pkg::DELAY_W-1:0]     w
);

  localparam int DW   = geq_pkg::DELAY_W;
  localparam int AW   = geq_pkg::ACC_W;
  localparam int MB_W = (COEF_WIDTH > geq_pkg::K_W) ? COEF_WIDTH : geq_pkg::K_W;
  localparam int PW   = DW + MB_W;

  localparam logic signed [DW:0] S_MAX = (DW+1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [DW:0] S_MIN = -S_MAX - (DW+1)'(1);

  function automatic logic signed [AW-1:0] sat_acc(input logic signed [AW:0] x);
    logic signed [AW-1:0] res;
    if (x[AW] != x[AW-1]) begin
      res = x[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      res = x[AW-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [DW-1:0] sat_dly(input logic signed [AW-1:0] x);
    logic [AW-DW:0]       top;
    logic signed [DW-1:0] res;
    top = x[AW-1:DW-1];
    if (top == '0 || top == '1) begin
      res = x[DW-1:0];
    end else begin
      res = x[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return res;
  endfunction

  logic signed [DW-1:0]   opa;
  logic signed [MB_W-1:0] opb;
  logic signed [PW-1:0]   prod_r;
  logic signed [AW-1:0]   acc_r;
  logic signed [DW-1:0]   y_r;
  logic signed [DW-1:0]   w_r;
  logic signed [DW-1:0]   m_r;
  logic signed [AW:0]     sum;
  logic signed [AW-1:0]   sum_sat;
  logic signed [AW-1:0]   mv;
  logic signed [AW-1:0]   yv;
  logic signed [DW-1:0]   w_nxt;
  logic signed [DW-1:0]   m_nxt;
  logic signed [DW-1:0]   y_nxt;

  always_comb begin
    unique case (ctl.mul_sel)
      geq_pkg::MS_Y_B0: begin
        opa = y_r;
        opb = MB_W'(b0);
      end
      geq_pkg::MS_D1_A0: begin
        opa = d1;
        opb = MB_W'(a0);
      end
      geq_pkg::MS_D2_A1: begin
        opa = d2;
        opb = MB_W'(a1);
      end
      geq_pkg::MS_D2_K: begin
        opa = d2;
        opb = MB_W'(geq_pkg::NEG_ONE_P005);
      end
      geq_pkg::MS_M_G: begin
        opa = m_r;
        opb = MB_W'(g);
      end
      default: begin
        opa = y_r;
        opb = MB_W'(b0);
      end
    endcase
  end

  assign sum     = (AW+1)'(acc_r) + (AW+1)'(prod_r);
  assign sum_sat = sat_acc(sum);
  assign w_nxt   = sat_dly(sum_sat >>> geq_pkg::COEF_FRAC);
  // difference term: w minus 1.005 of the older delay
  assign mv      = (AW'(w_r) <<< geq_pkg::COEF_FRAC) + AW'(prod_r);
  assign m_nxt   = sat_dly(mv >>> geq_pkg::COEF_FRAC);
  assign yv      = AW'(y_r) + (AW'(prod_r) >>> geq_pkg::GAIN_FRAC);
  assign y_nxt   = sat_dly(yv);

  always_ff @(posedge clk) begin
    prod_r <= PW'(opa) * PW'(opb);
    if (ctl.acc_ld) begin
      acc_r <= AW'(prod_r);
    end else if (ctl.acc_add) begin
      acc_r <= sum_sat;
    end
    if (ctl.w_cap) begin
      w_r <= w_nxt;
    end
    if (ctl.m_cap) begin
      m_r <= m_nxt;
    end
    if (ctl.y_load) begin
      y_r <= DW'(sample);
    end else if (ctl.y_upd) begin
      y_r <= y_nxt;
    end
  end

  always_comb begin
    if ((DW+1)'(y_r) > S_MAX) begin
      y_sat = SAMPLE_WIDTH'(S_MAX);
    end else if ((DW+1)'(y_r) < S_MIN) begin
      y_sat = SAMPLE_WIDTH'(S_MIN);
    end else begin
      y_sat = SAMPLE_WIDTH'(y_r);
    end
  end

  assign w = w_r;

endmodule

// ----- rtl/graphic_equalizer_bandpass_cascade_core.sv -----
// channel  dir  moves                                   when taken
// cfg_ch   in   register index, 4-bit data              valid & ready
// in_ch    in   action, sample, last, band, coefs, gain valid & ready
// out_ch   out  equalized sample, last flag             valid & ready
//
// A load word is taken while idle. A sample is accepted, walks each active band,
// and is handed off; bypass skips the band walk. The single shared multiplier
// walks each band in 7 steps against a delay RAM with separate read and write ports.
// Reset restores registers; delay and coefficient RAMs read as zero through
// per-entry valid flags, so no clearing sweep is needed.
// in_ch and cfg_ch are ready only while idle; the hand-off waits for out_ch.
module graphic_equalizer_bandpass_cascade_core #(
  parameter int MAX_CHANS    = 8,
  parameter int NUM_BANDS    = 10,
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  geq_cfg_if.sink   cfg_ch,
  geq_in_if.sink    in_ch,
  geq_out_if.source out_ch
);

  localparam int DW      = geq_pkg::DELAY_W;
  localparam int BW      = geq_pkg::BAND_W;
  localparam int CH_W    = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;
  localparam int CA_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int D_DEPTH = MAX_CHANS * NUM_BANDS;
  localparam int DA_W    = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;
  localparam int DRW     = 2 * DW;
  localparam int CRW     = 4 * COEF_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] PH_MUL_YB = 3'd1;
  localparam logic [2:0] PH_MUL_D1 = 3'd2;
  localparam logic [2:0] PH_MUL_D2 = 3'd3;
  localparam logic [2:0] PH_W      = 3'd4;
  localparam logic [2:0] PH_M      = 3'd5;
  localparam logic [2:0] PH_MUL_G  = 3'd6;
  localparam logic [2:0] PH_Y      = 3'd7;

  logic [1:0]      state_r, state_nxt;
  logic [2:0]      ph_r, ph_nxt;
  logic [BW-1:0]   k_r, k_nxt;
  logic [CH_W-1:0] ch_r;
  logic [CH_W-1:0] pos_r, pos_nxt;
  logic            last_r;
  logic            enable_r;
  logic [geq_pkg::CFG_DATA_W-1:0] num_ch_r;
  logic [geq_pkg::CFG_DATA_W-1:0] act_bands_r;
  logic [D_DEPTH-1:0]   dvalid_r;
  logic [NUM_BANDS-1:0] cvalid_r;
  logic            dvld_r;
  logic            cvld_r;
  logic            out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic            out_last_r;

  logic [4:0]      ncx;
  logic [CH_W:0]   chans;
  logic [CH_W-1:0] ch_cur;
  logic [CH_W:0]   ch_inc;
  logic [BW:0]     nb;
  logic [BW:0]     k_next;
  logic            more;
  logic            cfg_acc, in_acc, is_load, smp_go, run_go, out_free, dly_clr;
  logic [BW-1:0]   rd_k;
  logic [CH_W-1:0] rd_ch;

  logic            dly_we, dly_re;
  logic [DA_W-1:0] dly_waddr, dly_raddr;
  logic [DRW-1:0]  dly_wdata, dly_rdata;
  logic            coef_we;
  logic [CA_W-1:0] coef_waddr, coef_raddr;
  logic [CRW-1:0]  coef_wdata, coef_rdata;

  logic signed [DW-1:0]           d1, d2, w;
  logic signed [COEF_WIDTH-1:0]   a0, a1, b0, g;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  geq_pkg::mac_ctl_t              ctl;

  // effective channel and band counts
  always_comb begin
    if (num_ch_r == '0) begin
      ncx = 5'd1;
    end else if ({1'b0, num_ch_r} > 5'(MAX_CHANS)) begin
      ncx = 5'(MAX_CHANS);
    end else begin
      ncx = {1'b0, num_ch_r};
    end
  end
  assign chans = (CH_W+1)'(ncx);
  assign nb = ({1'b0, act_bands_r} > 5'(NUM_BANDS)) ? 5'(NUM_BANDS) : {1'b0, act_bands_r};

  assign ch_cur  = ({1'b0, pos_r} >= chans) ? '0 : pos_r;
  assign ch_inc  = {1'b0, ch_cur} + (CH_W+1)'(1);
  assign pos_nxt = in_ch.last_in ? '0 : ((ch_inc >= chans) ? '0 : ch_inc[CH_W-1:0]);

  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_load  = (in_ch.action == geq_pkg::ACT_LOAD);
  assign smp_go   = in_acc && !is_load;
  assign run_go   = smp_go && enable_r && (nb != '0);
  assign out_free = !out_valid_r || out_ch.ready;
  assign dly_clr  = cfg_acc && (cfg_ch.index == geq_pkg::REG_NUM_CHANNELS ||
                                cfg_ch.index == geq_pkg::REG_ACTIVE_BANDS);

  assign k_next = {1'b0, k_r} + (BW+1)'(1);
  assign more   = (k_next < nb);

  // delay RAM: {recent, older} per channel and band
  assign rd_k      = (state_r == ST_IDLE) ? '0 : k_next[BW-1:0];
  assign rd_ch     = (state_r == ST_IDLE) ? ch_cur : ch_r;
  assign dly_re    = run_go || (state_r == ST_RUN && ph_r == PH_Y && more);
  assign dly_raddr = DA_W'(rd_ch) * DA_W'(NUM_BANDS) + DA_W'(rd_k);
  assign dly_we    = (state_r == ST_RUN) && (ph_r == PH_Y);
  assign dly_waddr = DA_W'(ch_r) * DA_W'(NUM_BANDS) + DA_W'(k_r);
  assign dly_wdata = {w, d1};

  assign coef_we    = in_acc && is_load && ({1'b0, in_ch.band} < 5'(NUM_BANDS));
  assign coef_waddr = in_ch.band[CA_W-1:0];
  assign coef_wdata = {in_ch.coef_a0, in_ch.coef_a1, in_ch.coef_b0, in_ch.band_gain};
  assign coef_raddr = rd_k[CA_W-1:0];

  geq_ram #(.WIDTH(DRW), .DEPTH(D_DEPTH)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wdata),
    .re    (dly_re),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  geq_ram #(.WIDTH(CRW), .DEPTH(NUM_BANDS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .re    (dly_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // entries never written since the last clear read as zero
  assign d1 = dvld_r ? dly_rdata[DRW-1 -: DW] : '0;
  assign d2 = dvld_r ? dly_rdata[DW-1:0] : '0;
  assign a0 = cvld_r ? coef_rdata[CRW-1 -: COEF_WIDTH] : '0;
  assign a1 = cvld_r ? coef_rdata[3*COEF_WIDTH-1 -: COEF_WIDTH] : '0;
  assign b0 = cvld_r ? coef_rdata[2*COEF_WIDTH-1 -: COEF_WIDTH] : '0;
  assign g  = cvld_r ? coef_rdata[COEF_WIDTH-1:0] : '0;

  always_comb begin
    ctl         = '0;
    ctl.mul_sel = geq_pkg::MS_Y_B0;
    ctl.y_load  = smp_go;
    if (state_r == ST_RUN) begin
      unique case (ph_r)
        PH_MUL_YB: ctl.mul_sel = geq_pkg::MS_Y_B0;
        PH_MUL_D1: begin
          ctl.acc_ld  = 1'b1;
          ctl.mul_sel = geq_pkg::MS_D1_A0;
        end
        PH_MUL_D2: begin
          ctl.acc_add = 1'b1;
          ctl.mul_sel = geq_pkg::MS_D2_A1;
        end
        PH_W: begin
          ctl.w_cap   = 1'b1;
          ctl.mul_sel = geq_pkg::MS_D2_K;
        end
        PH_M:      ctl.m_cap = 1'b1;
        PH_MUL_G:  ctl.mul_sel = geq_pkg::MS_M_G;
        PH_Y:      ctl.y_upd = 1'b1;
        default: ;
      endcase
    end
  end

  geq_mac #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_mac (
    .clk    (clk),
    .ctl    (ctl),
    .sample (in_ch.sample_in),
    .d1     (d1),
    .d2     (d2),
    .a0     (a0),
    .a1     (a1),
    .b0     (b0),
    .g      (g),
    .y_sat  (y_sat),
    .w      (w)
  );

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (smp_go) begin
          k_nxt     = '0;
          ph_nxt    = PH_MUL_YB;
          state_nxt = run_go ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (ph_r == PH_Y) begin
          if (more) begin
            k_nxt  = k_next[BW-1:0];
            ph_nxt = PH_MUL_YB;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_MUL_YB;
      k_r         <= '0;
      pos_r       <= '0;
      enable_r    <= 1'b0;
      num_ch_r    <= geq_pkg::RESET_NUM_CHANNELS;
      act_bands_r <= geq_pkg::RESET_ACTIVE_BANDS;
      dvalid_r    <= '0;
      cvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      k_r     <= k_nxt;

      if (cfg_acc && cfg_ch.index == geq_pkg::REG_ENABLE) begin
        enable_r <= cfg_ch.data[0];
      end
      if (cfg_acc && cfg_ch.index == geq_pkg::REG_NUM_CHANNELS) begin
        num_ch_r <= cfg_ch.data;
      end
      if (cfg_acc && cfg_ch.index == geq_pkg::REG_ACTIVE_BANDS) begin
        act_bands_r <= cfg_ch.data;
      end

      if (dly_clr) begin
        dvalid_r <= '0;
        pos_r    <= '0;
      end else begin
        if (dly_we) begin
          dvalid_r[dly_waddr] <= 1'b1;
        end
        if (smp_go) begin
          pos_r <= pos_nxt;
        end
      end

      if (coef_we) begin
        cvalid_r[coef_waddr] <= 1'b1;
      end

      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_go) begin
      ch_r   <= ch_cur;
      last_r <= in_ch.last_in;
    end
    if (dly_re) begin
      dvld_r <= dvalid_r[dly_raddr];
      cvld_r <= cvalid_r[coef_raddr];
    end
    if (state_r == ST_DONE && out_free) begin
      out_sample_r <= y_sat;
      out_last_r   <= last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.last_out   = out_last_r;

`ifndef SYNTHESIS
  a_run_band_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> ({1'b0, k_r} < nb) && enable_r)
    else $error("band walk outside active bands or while disabled");

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    dly_we && dly_re |-> dly_waddr != dly_raddr)
    else $error("delay read and write hit the same entry");

  a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
    dly_we |=> dvalid_r[$past(dly_waddr)])
    else $error("written delay entry not marked valid");

  a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished sample not handed to output register");
`endif

endmodule

// ----- test/tb_graphic_equalizer_bandpass_cascade_core.sv -----
module tb_graphic_equalizer_bandpass_cascade_core;
  import geq_pkg::*;

  localparam int MAX_CHANS    = 8;
  localparam int NUM_BANDS    = 10;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int PHASE_WORDS   = 172;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 80;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = -24'sh800000;

  typedef struct {
    logic                           action;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
    logic [BAND_W-1:0]              band;
    logic signed [COEF_WIDTH-1:0]   a0;
    logic signed [COEF_WIDTH-1:0]   a1;
    logic signed [COEF_WIDTH-1:0]   b0;
    logic signed [COEF_WIDTH-1:0]   gain;
  } eq_word_t;

  typedef struct {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    last;
  } eq_result_t;

  class geq_scoreboard;
    bit                            enable;
    bit [CFG_DATA_W-1:0]           num_channels;
    bit [CFG_DATA_W-1:0]           active_bands;
    logic signed [DELAY_W-1:0]     delay_recent[MAX_CHANS*NUM_BANDS];
    logic signed [DELAY_W-1:0]     delay_older[MAX_CHANS*NUM_BANDS];
    logic signed [COEF_WIDTH-1:0]  fb_first[NUM_BANDS];
    logic signed [COEF_WIDTH-1:0]  fb_second[NUM_BANDS];
    logic signed [COEF_WIDTH-1:0]  in_scale[NUM_BANDS];
    logic signed [COEF_WIDTH-1:0]  gain_table[NUM_BANDS];
    int unsigned                   chan_pos;
    eq_result_t                    pending_out[$];
    int                            errors;
    int                            results_checked;
    int                            loads_taken;
    int                            reg_writes;
    int                            full_scale;

    function new();
      enable       = 1'b0;
      num_channels = RESET_NUM_CHANNELS;
      active_bands = RESET_ACTIVE_BANDS;
      clear_delays();
      foreach (fb_first[k]) begin
        fb_first[k]   = '0;
        fb_second[k]  = '0;
        in_scale[k]   = '0;
        gain_table[k] = '0;
      end
    endfunction

    function void clear_delays();
      foreach (delay_recent[i]) begin
        delay_recent[i] = '0;
        delay_older[i]  = '0;
      end
      chan_pos = 0;
    endfunction

    function int unsigned chan_count();
      if (num_channels == 0) return 1;
      if (num_channels > MAX_CHANS) return MAX_CHANS;
      return num_channels;
    endfunction

    function longint clamp(longint x, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_ENABLE: begin
          enable = data[0];
        end
        REG_NUM_CHANNELS: begin
          num_channels = data;
          clear_delays();
        end
        REG_ACTIVE_BANDS: begin
          active_bands = data;
          clear_delays();
        end
        default: ;
      endcase
    endfunction

    // Store a load word, or model a sample word and queue its output.
    function void note_input(eq_word_t word);
      int unsigned chans, ch, nb, k, i;
      longint      y, d1, d2, acc, w, m;
      eq_result_t  res;
      if (word.action == ACT_LOAD) begin
        loads_taken++;
        if (word.band < NUM_BANDS) begin
          fb_first[word.band]   = word.a0;
          fb_second[word.band]  = word.a1;
          in_scale[word.band]   = word.b0;
          gain_table[word.band] = word.gain;
        end
        return;
      end
      chans = chan_count();
      ch = (chan_pos >= chans) ? 0 : chan_pos;
      y = longint'(word.sample);
      if (enable) begin
        nb = (active_bands > NUM_BANDS) ? NUM_BANDS : active_bands;
        for (k = 0; k < nb; k++) begin
          i   = ch * NUM_BANDS + k;
          d1  = longint'(delay_recent[i]);
          d2  = longint'(delay_older[i]);
          acc = y * longint'(in_scale[k]) + d1 * longint'(fb_first[k])
              + d2 * longint'(fb_second[k]);
          w   = clamp(acc >>> COEF_FRAC, DELAY_W);
          acc = (w <<< COEF_FRAC) + d2 * longint'(NEG_ONE_P005);
          m   = clamp(acc >>> COEF_FRAC, DELAY_W);
          y   = clamp(y + ((m * longint'(gain_table[k])) >>> GAIN_FRAC), DELAY_W);
          delay_older[i]  = d1[DELAY_W-1:0];
          delay_recent[i] = w[DELAY_W-1:0];
        end
        y = clamp(y, SAMPLE_WIDTH);
        if (y == longint'(SAMPLE_MAX) || y == longint'(SAMPLE_MIN)) full_scale++;
      end
      if (word.last) chan_pos = 0;
      else chan_pos = (ch + 1 >= chans) ? 0 : ch + 1;
      res.sample = y[SAMPLE_WIDTH-1:0];
      res.last   = word.last;
      pending_out.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    task check_result(logic [SAMPLE_WIDTH-1:0] sample, logic last);
      eq_result_t exp_res;
      if (pending_out.size() == 0) begin
        report($sformatf("output word %h last %b with nothing pending", sample, last));
        return;
      end
      exp_res = pending_out.pop_front();
      results_checked++;
      if (sample !== exp_res.sample)
        report($sformatf("output %0d: sample %h, predicted %h", results_checked, sample,
                         exp_res.sample));
      if (last !== exp_res.last)
        report($sformatf("output %0d: last %b, predicted %b", results_checked, last,
                         exp_res.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  geq_cfg_if cfg_ch ();
  geq_in_if  in_ch ();
  geq_out_if out_ch ();

  graphic_equalizer_bandpass_cascade_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  geq_scoreboard sb = new();

  int send_idle_pct = 28;
  int recv_idle_pct = 66;
  int hold_left     = 0;
  int longest_stall = 0;
  int cycles;

  always #2 clk = ~clk;

  // Output side: check each accepted word, then pick ready for the next edge.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.sample_out, out_ch.last_out);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d outputs outstanding", cycles,
             sb.pending_out.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic eq_word_t noise_word();
    eq_word_t w;
    w.action = $urandom_range(1);
    w.sample = $urandom;
    w.last   = $urandom_range(1);
    w.band   = $urandom_range(15);
    w.a0     = $urandom;
    w.a1     = $urandom;
    w.b0     = $urandom;
    w.gain   = $urandom;
    return w;
  endfunction

  // Stable resonator: pole radius squared r in [0.5, 1), a0 inside the triangle.
  function automatic eq_word_t load_word(int unsigned band, bit wild);
    eq_word_t w;
    int       r, lim;
    w        = noise_word();
    w.action = ACT_LOAD;
    w.band   = band;
    if (!wild) begin
      r      = $urandom_range(2097152, 4190000);
      lim    = ((4194304 + r) / 100) * 95;
      w.a1   = -r;
      w.a0   = int'($urandom_range(0, 2 * lim)) - lim;
      w.b0   = int'($urandom_range(0, 838860)) - 419430;
      w.gain = int'($urandom_range(0, 1048576)) - 524288;
    end
    return w;
  endfunction

  function automatic eq_word_t sample_word(logic last);
    eq_word_t w;
    w        = noise_word();
    w.action = ACT_SAMPLE;
    w.last   = last;
    if ($urandom_range(3) != 0) w.sample = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    return w;
  endfunction

  task automatic send_word(eq_word_t w);
    int waited;
    waited = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.action    <= w.action;
    in_ch.sample_in <= w.sample;
    in_ch.last_in   <= w.last;
    in_ch.band      <= w.band;
    in_ch.coef_a0   <= w.a0;
    in_ch.coef_a1   <= w.a1;
    in_ch.coef_b0   <= w.b0;
    in_ch.band_gain <= w.gain;
    in_ch.valid     <= 1'b1;
    do begin
      @(posedge clk);
      waited++;
    end while (!in_ch.ready);
    sb.note_input(w);
    if (waited - 1 > longest_stall) longest_stall = waited - 1;
  endtask

  task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] value, logic last);
    eq_word_t w;
    w        = sample_word(last);
    w.sample = value;
    send_word(w);
  endtask

  task automatic send_load(int unsigned band, logic signed [COEF_WIDTH-1:0] a0,
                           logic signed [COEF_WIDTH-1:0] a1,
                           logic signed [COEF_WIDTH-1:0] b0,
                           logic signed [COEF_WIDTH-1:0] gain);
    eq_word_t w;
    w      = load_word(band, 1'b1);
    w.a0   = a0;
    w.a1   = a1;
    w.b0   = b0;
    w.gain = gain;
    send_word(w);
  endtask

  // Leaves valid high so back-to-back writes need no extra edge.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_regs(bit en, logic [CFG_DATA_W-1:0] chans,
                          logic [CFG_DATA_W-1:0] bands);
    cfg_write(REG_ENABLE, {3'($urandom_range(7)), en});
    cfg_write(REG_NUM_CHANNELS, chans);
    cfg_write(REG_ACTIVE_BANDS, bands);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait out every pending output, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int words, int unsigned chans, bit squeeze);
    eq_word_t w;
    int       n, pos, len;
    pos = 0;
    len = chans * $urandom_range(1, 6);
    for (n = 0; n < words; n++) begin
      if (squeeze && n == 20 && hold_left == 0) hold_left <= HOLD_CYCLES;
      if ($urandom_range(99) < 6) begin
        w = load_word(($urandom_range(99) < 15) ? $urandom_range(15) : $urandom_range(9),
                      $urandom_range(4) == 0);
      end else begin
        pos++;
        w = sample_word(pos >= len || $urandom_range(99) < 2);
        if (w.last) begin
          pos = 0;
          len = chans * $urandom_range(1, 6);
          // occasionally break the buffer framing
          if ($urandom_range(9) == 0) len += $urandom_range(1, 2);
        end
      end
      send_word(w);
    end
  endtask

  initial begin
    int                  p, b, waited;
    int                  chan_set[8];
    int                  band_set[8];
    bit                  en_set[8];
    chan_set = '{1, 8, 0, 15, 3, 2, 5, 9};
    band_set = '{10, 1, 0, 15, 4, 10, 7, 12};
    en_set   = '{1, 1, 1, 1, 0, 1, 1, 1};

    rst_n           <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_SAMPLE;
    in_ch.sample_in <= '0;
    in_ch.last_in   <= 1'b0;
    in_ch.band      <= '0;
    in_ch.coef_a0   <= '0;
    in_ch.coef_a1   <= '0;
    in_ch.coef_b0   <= '0;
    in_ch.band_gain <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(REG_SPARE, 4'hf);
    cfg_ch.valid <= 1'b0;

    // Bypass after reset, then loads the block must drop, then a load for every band.
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_load(15, '1, '1, '1, '1);
    send_load(NUM_BANDS, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    for (b = 0; b < NUM_BANDS; b++) send_word(load_word(b, 1'b0));

    drain();
    set_regs(1'b1, 4'd2, 4'd10);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    // extreme coefficients drive the delays and the output into saturation
    send_load(0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_load(1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, 1'b1);

    for (p = 0; p < 8; p++) begin
      drain();
      if (p < 3) begin
        send_idle_pct <= 28;
        recv_idle_pct <= 66;
      end else if (p < 6) begin
        send_idle_pct <= 66;
        recv_idle_pct <= 28;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      set_regs(en_set[p], chan_set[p], band_set[p]);
      for (b = 0; b < NUM_BANDS; b++) send_word(load_word(b, 1'b0));
      run_phase(PHASE_WORDS - NUM_BANDS, sb.chan_count(), p == 6);
    end

    in_ch.valid <= 1'b0;
    waited = 0;
    while (sb.pending_out.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_out.size() != 0)
      sb.report($sformatf("%0d predicted outputs never arrived", sb.pending_out.size()));

    $display("covered %0d equalized samples, %0d band loads, %0d register writes",
             sb.results_checked, sb.loads_taken, sb.reg_writes);
    $display("%0d outputs at full scale, input held off up to %0d cycles, %0d mismatches",
             sb.full_scale, longest_stall, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
